// ===== rtl/baro_sensor_compensation_assert.svh =====
// Assertion macros for the baro compensation block
`ifndef BARO_SENSOR_COMPENSATION_ASSERT_SVH
`define BARO_SENSOR_COMPENSATION_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define BSC_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
	else $error("assertion failed");
// next-cycle implication
`define BSC_ASSERT_NXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
	else $error("assertion failed");
`endif

// ===== rtl/bsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsc_pkg
// Types and constants shared by the barometric compensation block.
// ----------------------------------------------------------------------------
package bsc_pkg;
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned DIVW   = 32;

	localparam logic [1:0] REG_CAL_A = 2'd0;
	localparam logic [1:0] REG_CAL_B = 2'd1;
	localparam logic [1:0] REG_CAL_C = 2'd2;
	localparam logic [1:0] REG_OSS   = 2'd3;

	typedef struct packed {
		logic [15:0] raw_temp;
		logic [23:0] raw_press;
	} in_t;

	typedef struct packed {
		logic signed [27:0] temp_tenths;
		logic signed [31:0] press_pa;
		logic               div_error;
	} out_t;

	// divider request
	typedef struct packed {
		logic [31:0] num;
		logic [31:0] den;
	} div_req_t;

	function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
		asr = 32'($signed(x) >>> n);
	endfunction

	function automatic logic [31:0] sx16(input logic [15:0] v);
		sx16 = {{16{v[15]}}, v};
	endfunction
endpackage

// ===== rtl/bsc_udiv.sv =====
// ----------------------------------------------------------------------------
// bsc_udiv
// Pipelined 32-bit unsigned divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bsc_udiv #(
	parameter int unsigned W = bsc_pkg::DIVW,
	parameter int unsigned SW = 1
) (
	input  logic          clk,
	input  logic          en,
	input  logic [W-1:0]  num,
	input  logic [W-1:0]  den,
	input  logic [SW-1:0] side_in,
	output logic [W-1:0]  quo,
	output logic [SW-1:0] side_out
);
	logic [W-1:0]  n_q [1:W];
	logic [W-1:0]  d_q [1:W];
	logic [W-1:0]  r_q [1:W];
	logic [SW-1:0] s_q [1:W];

	for (genvar i = 0; i < W; i++) begin : g_st
		logic [W-1:0]  n_i, d_i, r_i;
		logic [SW-1:0] s_i;
		logic [W:0]    t;
		if (i == 0) begin : g_head
			assign n_i = num;
			assign d_i = den;
			assign r_i = '0;
			assign s_i = side_in;
		end else begin : g_body
			assign n_i = n_q[i];
			assign d_i = d_q[i];
			assign r_i = r_q[i];
			assign s_i = s_q[i];
		end
		assign t = {r_i, n_i[W-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				if (t >= {1'b0, d_i}) begin
					r_q[i+1] <= W'(t - {1'b0, d_i});
					n_q[i+1] <= {n_i[W-2:0], 1'b1};
				end else begin
					r_q[i+1] <= t[W-1:0];
					n_q[i+1] <= {n_i[W-2:0], 1'b0};
				end
				d_q[i+1] <= d_i;
				s_q[i+1] <= s_i;
			end
		end
	end

	assign quo      = n_q[W];
	assign side_out = s_q[W];
endmodule

// ===== rtl/bsc_front.sv =====
// ----------------------------------------------------------------------------
// bsc_front
// Accepts readings, computes temperature and the pressure divisor terms.
// Every step is a pipeline stage; stall freezes the whole pipe.
// ----------------------------------------------------------------------------
module bsc_front (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         in_v,
	input  bsc_pkg::in_t in_d,
	input  logic [63:0]  cal_a,
	input  logic [63:0]  cal_b,
	input  logic [47:0]  cal_c,
	input  logic [1:0]   oss,
	output logic         out_v,
	output logic [31:0]  temp,
	output logic [31:0]  b4,
	output logic [31:0]  b7,
	output logic         err
);
	localparam int unsigned DW = bsc_pkg::DIVW;
	localparam int unsigned SW = 1 + 1 + 32 + 32;

	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	always_comb begin
		ac1 = bsc_pkg::sx16(cal_a[15:0]);
		ac2 = bsc_pkg::sx16(cal_a[31:16]);
		ac3 = bsc_pkg::sx16(cal_a[47:32]);
		ac4 = {16'd0, cal_a[63:48]};
		ac5 = {16'd0, cal_b[15:0]};
		ac6 = {16'd0, cal_b[31:16]};
		b1  = bsc_pkg::sx16(cal_b[47:32]);
		b2  = bsc_pkg::sx16(cal_b[63:48]);
		mc  = bsc_pkg::sx16(cal_c[31:16]);
		md  = bsc_pkg::sx16(cal_c[47:32]);
	end

	// s1: x1 product
	logic v_s1; logic [31:0] x1p_s1, up_s1;
	// s2: den and signed divide setup
	logic v_s2; logic [31:0] x1_s2, num_s2, dd_s2, up_s2; logic neg_s2, z_s2;
	logic [SW-1:0] side_s2, side_dq;
	logic [DW-1:0] q_dq;
	logic [DW-1:0] v_dq;

	always_ff @(posedge clk) begin
		if (en) begin
			x1p_s1 <= 32'({16'd0, in_d.raw_temp} - ac6) * ac5;
			up_s1  <= 32'({8'd0, in_d.raw_press} >> (4'd8 - {2'd0, oss}));
		end
	end

	logic [31:0] x1c, denc, mnum;
	always_comb begin
		x1c  = bsc_pkg::asr(x1p_s1, 15);
		denc = x1c + md;
		mnum = mc << 11;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s2  <= x1c;
			up_s2  <= up_s1;
			z_s2   <= (denc == 32'd0);
			neg_s2 <= mnum[31] ^ denc[31];
			num_s2 <= mnum[31] ? 32'd0 - mnum : mnum;
			dd_s2  <= denc[31] ? 32'd0 - denc : denc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
		end
	end

	assign side_s2 = {z_s2, neg_s2, x1_s2, up_s2};
	bsc_udiv #(.W(DW), .SW(SW)) u_tdiv (
		.clk(clk), .en(en), .num(num_s2), .den(z_s2 ? 32'd1 : dd_s2),
		.side_in(side_s2), .quo(q_dq), .side_out(side_dq)
	);

	// valid bits alongside the divider stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_dq <= '0;
		else if (en) v_dq <= {v_dq[DW-2:0], v_s2};
	end

	// post-division stages
	logic        z_d, neg_d;
	logic [31:0] x1_d, up_d;
	assign {z_d, neg_d, x1_d, up_d} = side_dq;

	logic v_s3, z_s3; logic [31:0] b5_s3, up_s3;
	logic v_s4, z_s4; logic [31:0] b5_s4, b6_s4, sq_s4, up_s4;
	logic v_s5, z_s5; logic [31:0] b5_s5, up_s5, p1_s5, p2_s5, p3_s5, p4_s5;
	logic v_s6, z_s6; logic [31:0] b5_s6, up_s6, b3_s6, x3_s6;
	logic v_s7; logic [31:0] temp_s7, b4_s7, b7_s7; logic err_s7;

	logic [31:0] x2c;
	assign x2c = neg_d ? 32'd0 - q_dq : q_dq;

	always_ff @(posedge clk) begin
		if (en) begin
			z_s3 <= z_d; up_s3 <= up_d;
			b5_s3 <= x1_d + x2c;
			z_s4 <= z_s3; up_s4 <= up_s3; b5_s4 <= b5_s3;
			b6_s4 <= b5_s3 - 32'd4000;
			sq_s4 <= 32'((b5_s3 - 32'd4000) * bsc_pkg::asr(b5_s3 - 32'd4000, 12));
			z_s5 <= z_s4; up_s5 <= up_s4; b5_s5 <= b5_s4;
			p1_s5 <= 32'(b2 * sq_s4);
			p2_s5 <= 32'(ac2 * bsc_pkg::asr(b6_s4, 11));
			p3_s5 <= 32'(ac3 * b6_s4);
			p4_s5 <= 32'(b1 * sq_s4);
			z_s6 <= z_s5; up_s6 <= up_s5; b5_s6 <= b5_s5;
			b3_s6 <= bsc_pkg::asr(32'((32'(ac1 << 2)
				+ bsc_pkg::asr(p1_s5, 11) + p2_s5) << oss) + 32'd2, 2);
			x3_s6 <= bsc_pkg::asr(bsc_pkg::asr(p3_s5, 13)
				+ bsc_pkg::asr(p4_s5, 16) + 32'd2, 2);
			temp_s7 <= bsc_pkg::asr(b5_s6 + 32'd8, 4);
			b4_s7   <= 32'(ac4 * (x3_s6 + 32'd32768)) >> 15;
			b7_s7   <= 32'((up_s6 - b3_s6) * (32'd50000 >> oss));
			err_s7  <= z_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_dq[DW-1]; v_s4 <= v_s3; v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6;
		end
	end

	assign out_v = v_s7;
	assign temp  = temp_s7;
	assign b4    = b4_s7;
	assign b7    = b7_s7;
	assign err   = err_s7 | (b4_s7 == 32'd0);
endmodule

// ===== rtl/bsc_queue.sv =====
// ----------------------------------------------------------------------------
// bsc_queue
// Small FIFO between front and back parts.
// ----------------------------------------------------------------------------
module bsc_queue #(
	parameter int unsigned W = 8,
	parameter int unsigned D = bsc_pkg::QDEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         nempty,
	output logic         room
);
	localparam int unsigned AW = (D > 1) ? $clog2(D) : 1;
	logic [W-1:0] mem_q [D];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(D - 1)) ? '0 : wp_q + 1'b1;
			if (pop)  rp_q <= (rp_q == AW'(D - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	assign rdata  = mem_q[rp_q];
	assign nempty = (cnt_q != '0);
	assign room   = (cnt_q < (AW+1)'(D - 1));
endmodule

// ===== rtl/bsc_back.sv =====
// ----------------------------------------------------------------------------
// bsc_back
// Pressure divide and final polynomial correction, then the output register.
// ----------------------------------------------------------------------------
module bsc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_v,
	input  logic [31:0]   temp,
	input  logic [31:0]   b4,
	input  logic [31:0]   b7,
	input  logic          err,
	output logic          out_v,
	output bsc_pkg::out_t out_d
);
	localparam int unsigned DW = bsc_pkg::DIVW;
	localparam int unsigned SW = 34;

	logic [31:0] num;
	logic        lo;
	assign lo  = ~b7[31];
	assign num = lo ? (b7 << 1) : b7;

	logic [DW-1:0] q;
	logic [SW-1:0] sd;
	logic [DW-1:0] v_dq;
	bsc_udiv #(.W(DW), .SW(SW)) u_pdiv (
		.clk(clk), .en(en), .num(num), .den(err ? 32'd1 : b4),
		.side_in({err, lo, temp}), .quo(q), .side_out(sd)
	);

	// valid bits alongside the divider stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_dq <= '0;
		else if (en) v_dq <= {v_dq[DW-2:0], in_v};
	end

	logic v_s1, e_s1; logic [31:0] p_s1, t_s1, sq_s1, m_s1;
	logic v_s2, e_s2; logic [31:0] p_s2, t_s2, x1_s2, x2_s2;
	logic [31:0] pc, p8;
	assign pc = sd[32] ? q : (q << 1);
	assign p8 = bsc_pkg::asr(pc, 8);

	always_ff @(posedge clk) begin
		if (en) begin
			e_s1 <= sd[33]; t_s1 <= sd[31:0]; p_s1 <= pc;
			sq_s1 <= 32'(p8 * p8);
			m_s1  <= 32'((32'd0 - 32'd7357) * pc);
			e_s2 <= e_s1; t_s2 <= t_s1; p_s2 <= p_s1;
			x1_s2 <= bsc_pkg::asr(32'(sq_s1 * 32'd3038), 16);
			x2_s2 <= bsc_pkg::asr(m_s1, 16);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_dq[DW-1]; v_s2 <= v_s1;
		end
	end

	logic [31:0] pf;
	assign pf = p_s2 + bsc_pkg::asr(x1_s2 + x2_s2 + 32'd3791, 4);
	assign out_v = v_s2;
	always_comb begin
		out_d.div_error   = e_s2;
		out_d.temp_tenths = e_s2 ? '0 : t_s2[27:0];
		out_d.press_pa    = e_s2 ? '0 : pf;
	end
endmodule

// ===== rtl/baro_sensor_compensation.sv =====
// ----------------------------------------------------------------------------
// baro_sensor_compensation
// Integer temperature and pressure compensation of a barometric sensor.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  in      | in  | in_valid / in_stall  | bsc_pkg::in_t
//  out     | out | out_valid / out_stall| bsc_pkg::out_t
//  cfg     | in  | cfg_we               | cfg_idx, cfg_data
//
// One transaction enters per cycle while in_stall is low. The pipe is made
// mostly of the two bit-per-stage 32-bit dividers (temperature in front,
// pressure in back), plus 7 front stages, the queue and 2 back stages.
// Reset clears all valid bits, queue pointers and calibration registers.
// Front stalls when the queue is near full; back stalls when out_valid meets out_stall.
// The user must write calibration only while idle; the block does not enforce it.
module baro_sensor_compensation #(
	parameter int unsigned QDEPTH = bsc_pkg::QDEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  bsc_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output bsc_pkg::out_t out_data,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_idx,
	input  logic [63:0]   cfg_data
);
	logic [63:0] cal_a_q, cal_b_q;
	logic [47:0] cal_c_q;
	logic [1:0]  oss_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_a_q <= '0; cal_b_q <= '0; cal_c_q <= '0; oss_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				bsc_pkg::REG_CAL_A: cal_a_q <= cfg_data;
				bsc_pkg::REG_CAL_B: cal_b_q <= cfg_data;
				bsc_pkg::REG_CAL_C: cal_c_q <= cfg_data[47:0];
				bsc_pkg::REG_OSS:   oss_q   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// front runs whenever the queue can absorb what is in flight
	logic f_en, f_v, f_err, q_room, q_ne, b_en, q_pop;
	logic [31:0] f_temp, f_b4, f_b7;
	logic [96:0] q_rd;
	assign f_en     = q_room;
	assign in_stall = ~f_en;

	bsc_front u_front (
		.clk(clk), .arst_n(arst_n), .en(f_en), .in_v(in_valid), .in_d(in_data),
		.cal_a(cal_a_q), .cal_b(cal_b_q), .cal_c(cal_c_q), .oss(oss_q),
		.out_v(f_v), .temp(f_temp), .b4(f_b4), .b7(f_b7), .err(f_err)
	);

	bsc_queue #(.W(97), .D(QDEPTH)) u_q (
		.clk(clk), .arst_n(arst_n), .push(f_v & f_en),
		.wdata({f_err, f_temp, f_b4, f_b7}), .pop(q_pop),
		.rdata(q_rd), .nempty(q_ne), .room(q_room)
	);

	// back pipe advances unless a finished result is held
	assign b_en  = ~(out_valid & out_stall);
	assign q_pop = q_ne & b_en;

	bsc_back u_back (
		.clk(clk), .arst_n(arst_n), .en(b_en), .in_v(q_pop),
		.temp(q_rd[95:64]), .b4(q_rd[63:32]), .b7(q_rd[31:0]), .err(q_rd[96]),
		.out_v(out_valid), .out_d(out_data)
	);
endmodule

// ===== rtl/bsc_checker.sv =====
// ----------------------------------------------------------------------------
// bsc_checker
// Port-level checks of the compensation block.
// ----------------------------------------------------------------------------
`include "baro_sensor_compensation_assert.svh"
module bsc_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          out_valid,
	input logic          out_stall,
	input bsc_pkg::out_t out_data
);
	`BSC_ASSERT_NXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`BSC_ASSERT_NXT(a_stable, clk, arst_n, out_valid && out_stall, $stable(out_data))
	`BSC_ASSERT_IMP(a_err_zero, clk, arst_n, out_valid && out_data.div_error,
		out_data.press_pa == 32'd0 && out_data.temp_tenths == 28'd0)
endmodule

bind baro_sensor_compensation bsc_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid),
	.out_stall(out_stall), .out_data(out_data)
);
